>>> src/multi_level_silence_run_detector_core_defines.svh
// assertion macros for the silence run detector
// used by files that carry concurrent checks; no other dependencies
`ifndef MULTI_LEVEL_SILENCE_RUN_DETECTOR_CORE_DEFINES_SVH
`define MULTI_LEVEL_SILENCE_RUN_DETECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MLSR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MLSR_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MLSR_ASSERT(name, clk, rst, prop, msg)
`define MLSR_ASSERT_NEXT(name, clk, rst, pre, post, msg)
`endif

`endif

>>> src/mlsr_pkg.sv
// shared types and constants of the silence run detector
// no dependencies
package mlsr_pkg;

  localparam int LEVELS     = 16;
  localparam int LVL_W      = 6;
  localparam int POS_W      = 31;
  localparam int START_W    = 32;
  localparam int SMP_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam int LEN_W      = 34;

  localparam logic [LVL_W-1:0]   TOP_LEVEL_RST = LVL_W'(15);
  localparam logic [POS_W-1:0]   MIN_RUN_RST   = {POS_W{1'b1}};
  localparam logic [START_W-1:0] START_RST     = START_W'(0) - START_W'(MIN_RUN_RST);

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN   = 1'b1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               flush;
    logic [POS_W-1:0]   pos;
    logic [SMP_W-1:0]   peak;
    logic [START_W-1:0] next_pos;
  } token_t;

  typedef struct packed {
    logic               valid;
    logic [LVL_W-1:0]   level;
    logic [START_W-1:0] run_start;
    logic [POS_W-1:0]   run_end;
    logic               is_open;
  } result_t;

endpackage

>>> src/mlsr_in_if.sv
// input channel of the silence run detector: one sample or flush per transaction
// depends on mlsr_pkg
interface mlsr_in_if;
  import mlsr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [SMP_W-1:0] sample_left;
  logic signed [SMP_W-1:0] sample_right;
  logic [POS_W-1:0]        sample_position;
  logic                    last_in_block;

  modport source (output valid, command, sample_left, sample_right, sample_position,
                  last_in_block, input ready);
  modport sink (input valid, command, sample_left, sample_right, sample_position,
                last_in_block, output ready);
endinterface

>>> src/mlsr_out_if.sv
// result channel of the silence run detector: one reported run per transaction
// depends on mlsr_pkg
interface mlsr_out_if;
  import mlsr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [LVL_W-1:0]          level;
  logic signed [START_W-1:0] run_start;
  logic [POS_W-1:0]          run_end;
  logic                      is_open;
  logic                      last;

  modport source (output valid, level, run_start, run_end, is_open, last, input ready);
  modport sink (input valid, level, run_start, run_end, is_open, last, output ready);
endinterface

>>> src/mlsr_cfg_if.sv
// register write channel of the silence run detector
// depends on mlsr_pkg
interface mlsr_cfg_if;
  import mlsr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/mlsr_cell.sv
// one level of the detector: silent flag and run start, passes the item token on
// depends on mlsr_pkg
module mlsr_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [mlsr_pkg::LVL_W-1:0]   idx,
  input  logic [mlsr_pkg::LVL_W-1:0]   top_level,
  input  logic [mlsr_pkg::POS_W-1:0]   min_run,
  input  logic                         clear,
  input  logic [mlsr_pkg::START_W-1:0] clear_start,
  input  logic                         stall,
  input  mlsr_pkg::token_t             tok_in,
  output mlsr_pkg::token_t             tok_out,
  output mlsr_pkg::result_t            res
);
  import mlsr_pkg::*;

  logic               silent;
  logic [START_W-1:0] start;
  logic               in_use;
  logic               hit;
  logic [LEN_W-1:0]   len;
  logic               long_enough;

  assign in_use      = tok_in.valid && (idx <= top_level);
  assign hit         = SMP_W'(idx) < tok_in.peak;
  assign len         = {3'b000, tok_in.pos} - {{(LEN_W-START_W){start[START_W-1]}}, start};
  assign long_enough = $signed(len) >= $signed({3'b000, min_run});

  always_comb begin
    res.valid     = in_use && (tok_in.flush || (hit && silent && long_enough));
    res.level     = idx;
    res.run_start = (tok_in.flush && !silent) ? tok_in.next_pos : start;
    res.run_end   = tok_in.flush ? '0 : tok_in.pos;
    res.is_open   = tok_in.flush;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      silent        <= 1'b1;
      start         <= START_RST;
      tok_out.valid <= 1'b0;
    end else begin
      if (clear) begin
        silent <= 1'b1;
        start  <= clear_start;
      end else if (!stall && in_use && !tok_in.flush) begin
        if (hit) begin
          silent <= 1'b0;
        end else if (!silent) begin
          silent <= 1'b1;
          start  <= {1'b0, tok_in.pos};
        end
      end
      if (!stall) begin
        tok_out <= tok_in;
      end
    end
  end
endmodule

>>> src/mlsr_collect.sv
// result collector: holds the newest result until the next one or the item end
// marks last, then drives the output register; depends on mlsr_pkg, mlsr_out_if
module mlsr_collect (
  input  logic              clk,
  input  logic              rst,
  input  mlsr_pkg::result_t emit,
  input  logic              done,
  output logic              stall,
  mlsr_out_if.source        runs
);
  import mlsr_pkg::*;

  result_t pend;
  result_t out_res;
  logic    out_valid;
  logic    out_last;
  logic    out_free;
  logic    push;

  assign out_free = !out_valid || runs.ready;
  assign stall    = pend.valid && (emit.valid || done) && !out_free;
  assign push     = !stall && pend.valid && (emit.valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
        out_res   <= pend;
        out_last  <= !emit.valid;
      end else if (runs.ready) begin
        out_valid <= 1'b0;
      end
      if (!stall) begin
        if (emit.valid) begin
          pend <= emit;
        end else if (done) begin
          pend.valid <= 1'b0;
        end
      end
    end
  end

  assign runs.valid     = out_valid;
  assign runs.level     = out_res.level;
  assign runs.run_start = out_res.run_start;
  assign runs.run_end   = out_res.run_end;
  assign runs.is_open   = out_res.is_open;
  assign runs.last      = out_last;
endmodule

>>> src/multi_level_silence_run_detector_core.sv
// silence run detector top: an item token walks a chain of LEVELS cells, one per cycle
// while the collector does not stall; each level's result leaves once the next result or
// the chain end is reached; a new item is taken only when the chain is empty again
// reset: top_level 15, min_run_length max, all levels silent from minus that, position zero
// depends on mlsr_pkg, mlsr_in_if, mlsr_out_if, mlsr_cfg_if, mlsr_cell, mlsr_collect
`include "multi_level_silence_run_detector_core_defines.svh"

module multi_level_silence_run_detector_core (
  input logic        clk,
  input logic        rst,
  mlsr_in_if.sink    samples,
  mlsr_cfg_if.sink   cfg,
  mlsr_out_if.source runs
);
  import mlsr_pkg::*;

  logic [LVL_W-1:0]   top_level;
  logic [POS_W-1:0]   min_run;
  logic [START_W-1:0] next_pos;
  token_t             tok [LEVELS+1];
  result_t            res [LEVELS];
  result_t            emit;
  logic [LEVELS:0]    tok_vec;
  logic [LEVELS-1:0]  emit_vec;
  logic               busy;
  logic               stall;
  logic               accept;
  logic               cfg_we;
  logic               clear;
  logic [START_W-1:0] clear_start;
  logic [SMP_W-1:0]   abs_l;
  logic [SMP_W-1:0]   abs_r;

  always_comb begin
    for (int k = 0; k <= LEVELS; k++) begin
      tok_vec[k] = tok[k].valid;
    end
    emit = '0;
    for (int k = 0; k < LEVELS; k++) begin
      emit_vec[k] = res[k].valid;
      emit        = emit | (res[k].valid ? res[k] : '0);
    end
  end

  assign busy          = |tok_vec;
  assign samples.ready = !busy && !rst;
  assign accept        = samples.valid && samples.ready;
  assign cfg.ready     = !rst;
  assign cfg_we        = cfg.valid && cfg.ready;
  assign clear         = cfg_we && (cfg.index == CFG_MIN_RUN);
  assign clear_start   = START_W'(0) - {1'b0, cfg.data};

  assign abs_l = samples.sample_left[SMP_W-1] ? SMP_W'(0) - samples.sample_left
                                              : samples.sample_left;
  assign abs_r = samples.sample_right[SMP_W-1] ? SMP_W'(0) - samples.sample_right
                                               : samples.sample_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_level    <= TOP_LEVEL_RST;
      min_run      <= MIN_RUN_RST;
      next_pos     <= '0;
      tok[0].valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg.index)
          CFG_TOP_LEVEL: top_level <= cfg.data[LVL_W-1:0];
          CFG_MIN_RUN:   min_run   <= cfg.data;
          default:       ;
        endcase
      end
      if (accept) begin
        tok[0].valid    <= 1'b1;
        tok[0].flush    <= samples.command == CMD_FLUSH;
        tok[0].pos      <= samples.sample_position;
        tok[0].peak     <= (abs_l > abs_r) ? abs_l : abs_r;
        tok[0].next_pos <= next_pos;
        if (samples.command == CMD_SAMPLE) begin
          next_pos <= {1'b0, samples.sample_position} + START_W'(1);
        end
      end else if (!stall) begin
        tok[0].valid <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    mlsr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (LVL_W'(g)),
      .top_level   (top_level),
      .min_run     (min_run),
      .clear       (clear),
      .clear_start (clear_start),
      .stall       (stall),
      .tok_in      (tok[g]),
      .tok_out     (tok[g+1]),
      .res         (res[g])
    );
  end

  mlsr_collect u_collect (
    .clk   (clk),
    .rst   (rst),
    .emit  (emit),
    .done  (tok[LEVELS].valid),
    .stall (stall),
    .runs  (runs)
  );

  `MLSR_ASSERT(a_one_token, clk, rst, $onehot0(tok_vec), "more than one item in the cell chain")
  `MLSR_ASSERT(a_one_emit, clk, rst, $onehot0(emit_vec), "several cells report in one cycle")
  `MLSR_ASSERT_NEXT(a_stall_hold, clk, rst, stall, $stable(tok_vec), "chain moved while stalled")
  `MLSR_ASSERT_NEXT(a_accept_enter, clk, rst, accept, tok[0].valid, "accepted item not in chain")
endmodule
